// ===== hdl/lpab_pkg.sv =====
// Shared constants, types and helpers for the lidar packet angle binner.
package lpab_pkg;

   localparam int MAX_SAMPLES = 40;
   localparam int SMP_IDX_W   = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;

   localparam int MAP_SIZE = 360;
   localparam int BYTE_W   = 8;
   localparam int ANG_W    = 9;
   localparam int DIST_W   = 14;
   localparam int CNT_W    = 9;

   localparam logic [DIST_W-1:0] NO_RETURN   = DIST_W'(10000);
   localparam logic [BYTE_W-1:0] HDR_FIRST   = 8'hAA;
   localparam logic [BYTE_W-1:0] HDR_SECOND  = 8'h55;
   localparam logic [BYTE_W-1:0] DROP_COUNT  = 8'd1;

   // Bin offset is ((span * i) mod 2^32) / DIVISOR, kept modulo the map size. Carry the
   // running offset modulo DIVISOR map sizes from slot to slot and take a tenth of that.
   localparam int DIVISOR   = 10;
   localparam int ACC_W     = 32;
   localparam int RES_MOD   = DIVISOR * MAP_SIZE;
   localparam int RES_W     = $clog2(RES_MOD);
   localparam int WRAP_RES  = int'((64'd1 << ACC_W) % 64'(RES_MOD));
   localparam int SPAN_RES  = int'((64'd1 << (ACC_W - 2)) % 64'(RES_MOD));
   // reciprocal of ten, exact for every residue below 2^RES_W
   localparam int TENTH_SH  = 16;
   localparam int TENTH_MUL = (2**TENTH_SH + DIVISOR - 1) / DIVISOR;
   localparam int TENTH_W   = $clog2(TENTH_MUL + 1);

   typedef enum logic [2:0] {
      PH_HUNT,
      PH_TYPE,
      PH_COUNT,
      PH_START,
      PH_STOP,
      PH_CHECK,
      PH_DIST
   } phase_type;

   typedef enum logic [1:0] {
      BIN_IDLE,
      BIN_DIV,
      BIN_WRITE
   } bin_state_type;

   typedef struct packed {
      logic             go;
      logic [ANG_W-1:0] start_deg;
      logic [ANG_W-1:0] stop_deg;
   } fin_type;

   typedef struct packed {
      logic                 en;
      logic [SMP_IDX_W-1:0] addr;
      logic [DIST_W-1:0]    data;
   } smp_wr_type;

   typedef struct packed {
      logic              en;
      logic [ANG_W-1:0]  addr;
      logic [DIST_W-1:0] data;
   } map_wr_type;

   // ((lsb >> 1) + (msb << 7)) >> 6, kept to nine bits
   function automatic logic [ANG_W-1:0] decode_angle(input logic [BYTE_W-1:0] lsb,
                                                     input logic [BYTE_W-1:0] msb);
      return {msb, lsb[BYTE_W-1]};
   endfunction

endpackage

// ===== hdl/lidar_packet_angle_binner_unit.sv =====
// Lidar packet angle binner: top level with handshake and result register.
//
// Each accepted item is either one received byte (req_func 0, no result) or a lookup of one
// degree bin (req_func 1, one result). A lookup's result passes through the map memory's
// registered read and then the result register, and a new lookup waits until the previous
// result has been taken, while bytes keep flowing. When a packet ends, the binning sequencer
// walks all 40 sample slots, for each scaling the running bin offset (BIN_DIV) and then
// writing the map (BIN_WRITE), and no item is taken until the walk is done. After reset, a
// fill pass writes 10000 into all 360 map entries, one per cycle, and no item is taken until
// the fill pass is done. Lookups at 360 or above return 10000.
module lidar_packet_angle_binner_unit import lpab_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_func,
   input  logic [BYTE_W-1:0] req_rx_byte,
   input  logic [ANG_W-1:0]  req_read_angle,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [DIST_W-1:0] rsp_read_distance
);

   logic                 req_fire;
   logic                 byte_en;
   logic                 rd_en;
   logic                 slot_free;
   logic                 map_ready;
   logic                 bin_busy;
   logic                 rd_pend_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [DIST_W-1:0]    rsp_data_ff;
   logic [DIST_W-1:0]    map_rd_data;
   smp_wr_type           smp_wr;
   fin_type              fin;
   map_wr_type           map_wr;
   logic [SMP_IDX_W-1:0] smp_rd_addr;
   logic [DIST_W-1:0]    smp_rd_data;
   logic                 smp_clr;

   assign slot_free = ~rd_pend_ff & (~rsp_valid_ff | rsp_ready);
   assign req_ready = map_ready & ~bin_busy & (~req_func | slot_free);
   assign req_fire  = req_valid & req_ready;
   assign byte_en   = req_fire & ~req_func;
   assign rd_en     = req_fire & req_func;

   lpab_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .byte_en (byte_en),
      .rx_byte (req_rx_byte),
      .smp_wr  (smp_wr),
      .fin     (fin)
   );

   lpab_smp_buf u_smp_buf (
      .clock   (clock),
      .reset   (reset),
      .wr      (smp_wr),
      .clr     (smp_clr),
      .rd_addr (smp_rd_addr),
      .rd_data (smp_rd_data)
   );

   lpab_binner u_binner (
      .clock       (clock),
      .reset       (reset),
      .fin         (fin),
      .smp_rd_addr (smp_rd_addr),
      .smp_data    (smp_rd_data),
      .smp_clr     (smp_clr),
      .map_wr      (map_wr),
      .busy        (bin_busy)
   );

   lpab_dist_map u_dist_map (
      .clock   (clock),
      .reset   (reset),
      .wr      (map_wr),
      .rd_en   (rd_en),
      .rd_addr (req_read_angle),
      .rd_data (map_rd_data),
      .ready   (map_ready)
   );

   // load the result when the map read returns, drop it once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rd_pend_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_pend_ff   <= rd_en;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_pend_ff) begin
         rsp_data_ff <= map_rd_data;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_read_distance = rsp_data_ff;

endmodule

// ===== hdl/lpab_smp_buf.sv =====
// Sample buffer: one-write one-read memory with per-slot valid bits.
module lpab_smp_buf import lpab_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  smp_wr_type           wr,
   input  logic                 clr,
   input  logic [SMP_IDX_W-1:0] rd_addr,
   output logic [DIST_W-1:0]    rd_data
);

   logic [DIST_W-1:0]      mem [MAX_SAMPLES];
   logic [MAX_SAMPLES-1:0] valid_ff, valid_in;
   logic [DIST_W-1:0]      rd_q_ff;
   logic                   rd_valid_ff;

   always_comb begin
      valid_in = valid_ff;
      if (clr) begin
         valid_in = '0;
      end else if (wr.en) begin
         valid_in[wr.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_q_ff <= mem[rd_addr];
   end

   // a slot never written since the last packet reads as zero
   assign rd_data = rd_valid_ff ? rd_q_ff : '0;

endmodule

// ===== hdl/lpab_parser.sv =====
// Byte stream parser: header hunt, packet fields and sample capture.
module lpab_parser import lpab_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              byte_en,
   input  logic [BYTE_W-1:0] rx_byte,
   output smp_wr_type        smp_wr,
   output fin_type           fin
);

   phase_type         phase_ff, phase_in;
   logic [BYTE_W-1:0] prev_ff;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [BYTE_W-1:0] count_ff, count_in;
   logic [ANG_W-1:0]  start_ff, start_in;
   logic [ANG_W-1:0]  stop_ff, stop_in;
   logic [CNT_W-1:0]  cnt_inc;
   logic [CNT_W-1:0]  dist_len;
   logic              dist_last;
   logic              finish;

   assign cnt_inc   = cnt_ff + CNT_W'(1);
   assign dist_len  = {count_ff, 1'b0};
   assign dist_last = (cnt_inc >= dist_len);

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (byte_en) begin
         case (phase_ff)
            PH_HUNT: begin
               if (rx_byte == HDR_SECOND && prev_ff == HDR_FIRST) begin
                  phase_in = PH_TYPE;
               end
            end
            PH_TYPE:  phase_in = PH_COUNT;
            PH_COUNT: phase_in = (rx_byte == DROP_COUNT) ? PH_HUNT : PH_START;
            PH_START: begin
               if (cnt_ff != '0) begin
                  phase_in = PH_STOP;
               end
            end
            PH_STOP: begin
               if (cnt_ff != '0) begin
                  phase_in = PH_CHECK;
               end
            end
            PH_CHECK: begin
               if (cnt_ff != '0) begin
                  phase_in = (count_ff == '0) ? PH_HUNT : PH_DIST;
               end
            end
            PH_DIST: begin
               if (dist_last) begin
                  phase_in = PH_HUNT;
               end
            end
            default: phase_in = PH_HUNT;
         endcase
      end
   end

   // field registers and outputs
   always_comb begin
      cnt_in   = cnt_ff;
      count_in = count_ff;
      start_in = start_ff;
      stop_in  = stop_ff;
      finish   = 1'b0;
      if (byte_en) begin
         case (phase_ff)
            PH_HUNT, PH_TYPE: begin
            end
            PH_COUNT: begin
               cnt_in   = '0;
               count_in = (rx_byte == DROP_COUNT) ? '0 : rx_byte;
            end
            PH_START, PH_STOP, PH_CHECK: begin
               if (cnt_ff == '0) begin
                  cnt_in = CNT_W'(1);
               end else begin
                  cnt_in = '0;
                  if (phase_ff == PH_START) begin
                     start_in = decode_angle(prev_ff, rx_byte);
                  end else if (phase_ff == PH_STOP) begin
                     stop_in = decode_angle(prev_ff, rx_byte);
                  end else if (count_ff == '0) begin
                     finish = 1'b1;
                  end
               end
            end
            PH_DIST: begin
               cnt_in = cnt_inc;
               finish = dist_last;
            end
            default: cnt_in = '0;
         endcase
         if (finish) begin
            cnt_in   = '0;
            count_in = '0;
            start_in = '0;
            stop_in  = '0;
         end
      end
   end

   always_comb begin
      smp_wr.en   = byte_en && phase_ff == PH_DIST && cnt_ff[0]
                    && cnt_ff[CNT_W-1:1] < (CNT_W-1)'(MAX_SAMPLES);
      smp_wr.addr = cnt_ff[SMP_IDX_W:1];
      smp_wr.data = {rx_byte, prev_ff[BYTE_W-1:2]};
      fin.go        = finish;
      fin.start_deg = start_ff;
      fin.stop_deg  = stop_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         prev_ff  <= '0;
         cnt_ff   <= '0;
         count_ff <= '0;
         start_ff <= '0;
         stop_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         count_ff <= count_in;
         start_ff <= start_in;
         stop_ff  <= stop_in;
         if (byte_en) begin
            prev_ff <= rx_byte;
         end
      end
   end

endmodule

// ===== hdl/lpab_binner.sv =====
// Packet-end sequencer: walks the sample slots and writes each into its degree bin.
module lpab_binner import lpab_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  fin_type              fin,
   output logic [SMP_IDX_W-1:0] smp_rd_addr,
   input  logic [DIST_W-1:0]    smp_data,
   output logic                 smp_clr,
   output map_wr_type           map_wr,
   output logic                 busy
);

   localparam logic [SMP_IDX_W-1:0] IDX_LAST = SMP_IDX_W'(MAX_SAMPLES - 1);
   localparam int                   PROD_W   = RES_W + TENTH_W;

   bin_state_type        state_ff, state_in;
   logic [ANG_W-1:0]     start_ff, start_in;
   logic [ACC_W-1:0]     span_ff, span_in;
   logic [RES_W-1:0]     span_res_ff, span_res_in;
   logic [ACC_W-1:0]     acc_ff, acc_in;
   logic [RES_W-1:0]     res_ff, res_in;
   logic [SMP_IDX_W-1:0] idx_ff, idx_in;
   logic [ANG_W-1:0]     qm_ff, qm_in;

   logic [ACC_W-1:0]     span_new;
   logic [RES_W-1:0]     span_res_new;
   logic [ACC_W:0]       acc_sum;
   logic [RES_W+1:0]     res_sum;
   logic [RES_W-1:0]     res_nx;
   logic [PROD_W-1:0]    tenth_prod;
   logic [ANG_W:0]       bin_sum;
   logic [ANG_W-1:0]     bin;

   // span in 32-bit wrapping arithmetic, then quartered
   always_comb begin
      logic [ACC_W-1:0] start_ext;
      logic [ACC_W-1:0] stop_ext;
      logic [ACC_W-1:0] diff;
      start_ext = ACC_W'(fin.start_deg);
      stop_ext  = ACC_W'(fin.stop_deg);
      if (fin.stop_deg < fin.start_deg) begin
         diff = stop_ext + ACC_W'(MAP_SIZE) - start_ext;
      end else begin
         diff = stop_ext - start_ext;
      end
      span_new = diff >> 2;
      // a negative difference leaves 2^30 less at most 38, whose low bits are 4096 less
      // the same; any other span is below 128 and is its own residue
      if (span_new[ACC_W-3]) begin
         span_res_new = span_new[RES_W-1:0] + RES_W'(SPAN_RES);
      end else begin
         span_res_new = span_new[RES_W-1:0];
      end
   end

   // advance the offset residue; a 32-bit wrap of the offset takes 2^32 away from it
   always_comb begin
      acc_sum = {1'b0, acc_ff} + {1'b0, span_ff};
      res_sum = {2'b00, res_ff} + {2'b00, span_res_ff};
      if (acc_sum[ACC_W]) begin
         res_sum = res_sum + (RES_W+2)'(RES_MOD - WRAP_RES);
      end
      if (res_sum >= (RES_W+2)'(RES_MOD)) begin
         res_sum = res_sum - (RES_W+2)'(RES_MOD);
      end
      if (res_sum >= (RES_W+2)'(RES_MOD)) begin
         res_sum = res_sum - (RES_W+2)'(RES_MOD);
      end
      res_nx = res_sum[RES_W-1:0];
   end

   // a tenth of the residue is the offset modulo the map size
   assign tenth_prod = PROD_W'(res_ff) * PROD_W'(TENTH_MUL);

   // start may reach 511, so the bin can need two folds
   always_comb begin
      bin_sum = {1'b0, start_ff} + {1'b0, qm_ff};
      if (bin_sum >= (ANG_W+1)'(MAP_SIZE)) begin
         bin_sum = bin_sum - (ANG_W+1)'(MAP_SIZE);
      end
      if (bin_sum >= (ANG_W+1)'(MAP_SIZE)) begin
         bin_sum = bin_sum - (ANG_W+1)'(MAP_SIZE);
      end
      bin = bin_sum[ANG_W-1:0];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BIN_IDLE: begin
            if (fin.go) begin
               state_in = BIN_DIV;
            end
         end
         BIN_DIV:   state_in = BIN_WRITE;
         BIN_WRITE: state_in = (idx_ff == IDX_LAST) ? BIN_IDLE : BIN_DIV;
         default:   state_in = BIN_IDLE;
      endcase
   end

   // datapath registers
   always_comb begin
      start_in    = start_ff;
      span_in     = span_ff;
      span_res_in = span_res_ff;
      acc_in      = acc_ff;
      res_in      = res_ff;
      idx_in      = idx_ff;
      qm_in       = qm_ff;
      case (state_ff)
         BIN_IDLE: begin
            if (fin.go) begin
               start_in    = fin.start_deg;
               span_in     = span_new;
               span_res_in = span_res_new;
               acc_in      = '0;
               res_in      = '0;
               idx_in      = '0;
            end
         end
         BIN_DIV: begin
            qm_in = tenth_prod[TENTH_SH +: ANG_W];
         end
         BIN_WRITE: begin
            acc_in = acc_sum[ACC_W-1:0];
            res_in = res_nx;
            idx_in = idx_ff + SMP_IDX_W'(1);
         end
         default: begin
         end
      endcase
   end

   // outputs
   always_comb begin
      busy        = (state_ff != BIN_IDLE);
      smp_rd_addr = idx_ff;
      smp_clr     = (state_ff == BIN_WRITE) && (idx_ff == IDX_LAST);
      map_wr.en   = (state_ff == BIN_WRITE);
      map_wr.addr = bin;
      map_wr.data = (smp_data != '0) ? smp_data : NO_RETURN;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BIN_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff    <= start_in;
      span_ff     <= span_in;
      span_res_ff <= span_res_in;
      acc_ff      <= acc_in;
      res_ff      <= res_in;
      qm_ff       <= qm_in;
   end

endmodule

// ===== hdl/lpab_dist_map.sv =====
// Distance map memory with the post-reset fill pass and the lookup port.
module lpab_dist_map import lpab_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  map_wr_type        wr,
   input  logic              rd_en,
   input  logic [ANG_W-1:0]  rd_addr,
   output logic [DIST_W-1:0] rd_data,
   output logic              ready
);

   localparam logic [ANG_W-1:0] ADDR_LAST = ANG_W'(MAP_SIZE - 1);

   logic [DIST_W-1:0] mem [MAP_SIZE];
   logic              clr_busy_ff, clr_busy_in;
   logic [ANG_W-1:0]  clr_addr_ff, clr_addr_in;
   logic              rd_oor;
   logic              rd_oor_ff;
   logic [DIST_W-1:0] rd_q_ff;

   assign rd_oor = (rd_addr >= ANG_W'(MAP_SIZE));

   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + ANG_W'(1);
         if (clr_addr_ff == ADDR_LAST) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         mem[clr_addr_ff] <= NO_RETURN;
      end else if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_oor_ff <= rd_oor;
         rd_q_ff   <= mem[rd_oor ? '0 : rd_addr];
      end
   end

   assign rd_data = rd_oor_ff ? NO_RETURN : rd_q_ff;
   assign ready   = ~clr_busy_ff;

endmodule

// ===== hdl/lpab_checker.sv =====
// Port-level checks for the binner top level, attached by bind.
module lpab_checker import lpab_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              req_func,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [DIST_W-1:0] rsp_read_distance
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_distance))
      else $error("result changed while stalled");

   // a new result follows a lookup item, through the map read register and the result register
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && req_func, 2))
      else $error("result without a lookup item");

   // the map fill pass blocks input after reset
   assert property (@(posedge clock) reset |=> !req_ready)
      else $error("input taken during map fill");

   // no lookup while a result waits, and no two lookups in a row
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_func |-> !(rsp_valid && !rsp_ready))
      else $error("lookup taken while result stalled");

   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_func |=> !(req_valid && req_ready && req_func))
      else $error("back-to-back lookups");

endmodule

bind lidar_packet_angle_binner_unit lpab_checker u_lpab_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .req_func          (req_func),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_read_distance (rsp_read_distance)
);
